FILE: rtl/pru_pkg.sv
// Shared word types, register indexes and fixed field widths of the pixel replication upscaler.
package pru_pkg;

    localparam int PIX_WORD_BITS  = 32;
    localparam int SCALE_REG_BITS = 5;
    localparam int WIDTH_REG_BITS = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_X    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_Y    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [PIX_WORD_BITS-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_WORD_BITS-1:0] pixel_out;
        logic                     last_of_run;
        logic                     end_of_line;
        logic                     order_error;
    } t_out_word;

    // Flags of one run command handed from the front to the back.
    typedef struct packed {
        logic eol;
        logic err;
    } t_run_ctl;

endpackage

FILE: rtl/pru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pru_queue.sv
// Small register-based FIFO that decouples the command front from the copy back end.
module pru_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wptr, n_wptr;
    logic [PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];

endmodule

FILE: rtl/pru_front.sv
// Front end: configuration registers, item classification, line store access and run commands.
module pru_front import pru_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int PIXEL_BITS     = 32,
    parameter int MAX_SCALE      = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]                i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                 i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  t_in_word                                 i_in_word,
    output logic                                     o_push,
    output logic [(PIXEL_BITS < PIX_WORD_BITS ? PIXEL_BITS : PIX_WORD_BITS)-1:0] o_push_pix,
    output logic [(MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1)-1:0] o_push_cnt,
    output t_run_ctl                                 o_push_ctl,
    input  logic                                     i_q_full
);

    localparam int STORE_BITS = (PIXEL_BITS < PIX_WORD_BITS) ? PIXEL_BITS : PIX_WORD_BITS;
    localparam int COL_BITS   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int CNT_BITS   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int WID_BITS   = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMP_BITS   = (WID_BITS > WIDTH_REG_BITS) ? WID_BITS : WIDTH_REG_BITS;

    // A scale of zero acts as one and a scale above the maximum is clamped.
    function automatic logic [CNT_BITS-1:0] scale_less_one(
        input logic [SCALE_REG_BITS-1:0] s
    );
        logic [CNT_BITS-1:0] r;
        if (s == '0) begin
            r = '0;
        end else if (int'(s) > MAX_SCALE) begin
            r = CNT_BITS'(MAX_SCALE - 1);
        end else begin
            r = CNT_BITS'(s - SCALE_REG_BITS'(1));
        end
        return r;
    endfunction

    logic [SCALE_REG_BITS-1:0] r_scale_x;
    logic [SCALE_REG_BITS-1:0] r_scale_y;
    logic [WIDTH_REG_BITS-1:0] r_line_width;

    logic [COL_BITS-1:0] r_load_col, n_load_col;
    logic [COL_BITS-1:0] r_replay_col, n_replay_col;
    logic [CNT_BITS-1:0] r_replays, n_replays;

    logic                  r_s1_valid, n_s1_valid;
    logic                  r_s1_use_ram;
    logic [STORE_BITS-1:0] r_s1_pix;
    logic [CNT_BITS-1:0]   r_s1_cnt;
    t_run_ctl              r_s1_ctl;

    logic                  accept;
    logic                  is_load;
    logic                  is_err;
    logic                  load_eol;
    logic                  replay_eol;
    logic                  eol;
    logic [CMP_BITS-1:0]   eff_wid;
    logic                  ram_we;
    logic                  ram_re;
    logic [STORE_BITS-1:0] ram_q;

    assign o_push     = r_s1_valid && !i_q_full;
    assign o_in_ready = !r_s1_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign is_load = (i_in_word.opcode == OP_LOAD);
    assign is_err  = is_load ? (r_replays != '0) : (r_replays == '0);

    always_comb begin
        if (r_line_width == '0) begin
            eff_wid = CMP_BITS'(1);
        end else if (CMP_BITS'(r_line_width) > CMP_BITS'(MAX_LINE_WIDTH)) begin
            eff_wid = CMP_BITS'(MAX_LINE_WIDTH);
        end else begin
            eff_wid = CMP_BITS'(r_line_width);
        end
    end

    assign load_eol   = (CMP_BITS'(r_load_col) + CMP_BITS'(1)) >= eff_wid;
    assign replay_eol = (CMP_BITS'(r_replay_col) + CMP_BITS'(1)) >= eff_wid;
    assign eol        = is_load ? load_eol : replay_eol;

    assign ram_we = accept && is_load && !is_err;
    assign ram_re = accept && !is_load && !is_err;

    always_comb begin
        n_load_col   = r_load_col;
        n_replay_col = r_replay_col;
        n_replays    = r_replays;
        if (accept && !is_err) begin
            if (is_load) begin
                if (load_eol) begin
                    n_load_col   = '0;
                    n_replay_col = '0;
                    n_replays    = scale_less_one(r_scale_y);
                end else begin
                    n_load_col = r_load_col + COL_BITS'(1);
                end
            end else begin
                if (replay_eol) begin
                    n_replay_col = '0;
                    n_replays    = r_replays - CNT_BITS'(1);
                end else begin
                    n_replay_col = r_replay_col + COL_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x    <= SCALE_REG_BITS'(1);
            r_scale_y    <= SCALE_REG_BITS'(1);
            r_line_width <= WIDTH_REG_BITS'(1);
            r_load_col   <= '0;
            r_replay_col <= '0;
            r_replays    <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCALE_X:    r_scale_x    <= i_cfg_data[SCALE_REG_BITS-1:0];
                    CFG_SCALE_Y:    r_scale_y    <= i_cfg_data[SCALE_REG_BITS-1:0];
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_data[WIDTH_REG_BITS-1:0];
                    default: ;
                endcase
            end
            r_load_col   <= n_load_col;
            r_replay_col <= n_replay_col;
            r_replays    <= n_replays;
            r_s1_valid   <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_ram <= !is_load && !is_err;
            r_s1_pix     <= is_err ? '0 : i_in_word.pixel_in[STORE_BITS-1:0];
            r_s1_cnt     <= is_err ? '0 : scale_less_one(r_scale_x);
            r_s1_ctl.eol <= eol && !is_err;
            r_s1_ctl.err <= is_err;
        end
    end

    pru_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_col),
        .i_wdata (i_in_word.pixel_in[STORE_BITS-1:0]),
        .i_re    (ram_re),
        .i_raddr (r_replay_col),
        .o_rdata (ram_q)
    );

    assign o_push_pix = r_s1_use_ram ? ram_q : r_s1_pix;
    assign o_push_cnt = r_s1_cnt;
    assign o_push_ctl = r_s1_ctl;

endmodule

FILE: rtl/pru_back.sv
// Back end: expands each run command into its copies and holds them in the output register.
module pru_back import pru_pkg::*; #(
    parameter int STORE_BITS = 32,
    parameter int CNT_BITS   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [STORE_BITS-1:0] i_q_pix,
    input  logic [CNT_BITS-1:0]   i_q_cnt,
    input  t_run_ctl              i_q_ctl,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word
);

    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word;
    logic [CNT_BITS-1:0] r_copy, n_copy;
    logic                load_out;
    logic                emit;
    logic                last;

    assign load_out = !r_out_valid || i_out_ready;
    assign emit     = load_out && i_q_valid;
    assign last     = (r_copy == i_q_cnt);
    assign o_q_pop  = emit && last;

    always_comb begin
        n_out_valid = load_out ? i_q_valid : r_out_valid;
        n_copy      = r_copy;
        if (emit) begin
            n_copy = last ? '0 : r_copy + CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_copy      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_copy      <= n_copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.pixel_out   <= PIX_WORD_BITS'(i_q_pix);
            r_out_word.last_of_run <= last;
            r_out_word.end_of_line <= last && i_q_ctl.eol;
            r_out_word.order_error <= i_q_ctl.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/pixel_replication_upscaler.sv
// Top level of the pixel replication upscaler: front end, command queue and copy back end.
//
//  Channel   Direction  Signals                              Moves
//  cfg       in         i_cfg_valid/o_cfg_ready, index, data  one register write
//  in        in         i_in_valid/o_in_ready, i_in_word      one load or replay word
//  out       out        o_out_valid/i_out_ready, o_out_word   one output pixel word
//
// Each input word becomes one run of scale_x output words (one word for an ordering error).
// The back end sends one output word per cycle while i_out_ready is high; with scale_x of one
// a new input word is taken every cycle as long as the output side does not stall.
// A replay word reads the line store in the cycle it is taken; its pixel comes from the
// registered read port in the next cycle and is held until the command enters the queue.
// Reset is synchronous and active low; the line store is not cleared and needs no clearing pass.
// The command queue lets the front keep taking words while the back end still drains a run;
// the front stalls only when the queue is full and its own stage register holds a command.
module pixel_replication_upscaler import pru_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int PIXEL_BITS     = 32,
    parameter int MAX_SCALE      = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_word                  i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_word                 o_out_word
);

    // Stored pixels never exceed the 32-bit output word.
    localparam int STORE_BITS = (PIXEL_BITS < PIX_WORD_BITS) ? PIXEL_BITS : PIX_WORD_BITS;
    localparam int CNT_BITS   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int CTL_BITS   = $bits(t_run_ctl);
    localparam int Q_BITS     = STORE_BITS + CNT_BITS + CTL_BITS;
    localparam int Q_DEPTH    = 4;

    logic                  push;
    logic [STORE_BITS-1:0] push_pix;
    logic [CNT_BITS-1:0]   push_cnt;
    t_run_ctl              push_ctl;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [Q_BITS-1:0]     q_data;
    t_run_ctl              q_ctl;

    // Register writes are always taken at once.
    assign o_cfg_ready = 1'b1;

    pru_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .PIXEL_BITS     (PIXEL_BITS),
        .MAX_SCALE      (MAX_SCALE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_push      (push),
        .o_push_pix  (push_pix),
        .o_push_cnt  (push_cnt),
        .o_push_ctl  (push_ctl),
        .i_q_full    (q_full)
    );

    pru_queue #(
        .WIDTH (Q_BITS),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_pix, push_cnt, push_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_ctl = q_data[CTL_BITS-1:0];

    pru_back #(
        .STORE_BITS (STORE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_pix     (q_data[Q_BITS-1:CNT_BITS+CTL_BITS]),
        .i_q_cnt     (q_data[CNT_BITS+CTL_BITS-1:CTL_BITS]),
        .i_q_ctl     (q_ctl),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the pixel replication upscaler: directed cases, random lines, checked words.
module tb;
    import pru_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam int SCALE_CAP  = 16;

    // The scoreboard predicts the output words of every accepted input word and keeps them
    // in order until the block produces them.
    class upscale_scoreboard;
        logic [PIX_WORD_BITS-1:0]  line_pix [LINE_DEPTH];
        bit                        written [LINE_DEPTH];
        logic [11:0]               load_col;
        logic [11:0]               replay_col;
        logic [3:0]                repeats_owed;
        logic [SCALE_REG_BITS-1:0] sx_reg;
        logic [SCALE_REG_BITS-1:0] sy_reg;
        logic [WIDTH_REG_BITS-1:0] width_reg;
        t_out_word                 pending_pixels [$];
        int unsigned               mismatch_count;
        int unsigned               words_checked;

        function new();
            foreach (written[i]) begin
                written[i]  = 1'b0;
                line_pix[i] = '0;
            end
            load_col       = '0;
            replay_col     = '0;
            repeats_owed   = '0;
            sx_reg         = 1;
            sy_reg         = 1;
            width_reg      = 1;
            mismatch_count = 0;
            words_checked  = 0;
        endfunction

        // Out-of-range scales are pinned: zero acts as one, anything past the cap as the cap.
        function int unsigned eff_scale(logic [SCALE_REG_BITS-1:0] s);
            if (s == 0) return 1;
            if (s > SCALE_CAP) return SCALE_CAP;
            return s;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_SCALE_X: begin
                    sx_reg = val[SCALE_REG_BITS-1:0];
                end
                CFG_SCALE_Y: begin
                    sy_reg = val[SCALE_REG_BITS-1:0];
                end
                CFG_LINE_WIDTH: begin
                    width_reg = val[WIDTH_REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // An ignored word yields a single flagged word with a zero pixel.
        function void push_error();
            t_out_word w;
            w             = '0;
            w.last_of_run = 1'b1;
            w.order_error = 1'b1;
            pending_pixels.push_back(w);
        endfunction

        function void push_run(logic [PIX_WORD_BITS-1:0] pix, bit eol);
            int unsigned n;
            t_out_word   w;
            n = eff_scale(sx_reg);
            for (int unsigned k = 0; k < n; k++) begin
                w.pixel_out   = pix;
                w.last_of_run = (k + 1 == n);
                w.end_of_line = (k + 1 == n) && eol;
                w.order_error = 1'b0;
                pending_pixels.push_back(w);
            end
        endfunction

        function void take_input(t_in_word item);
            int unsigned wid;
            bit          eol;
            wid = eff_width();
            if (item.opcode == OP_LOAD) begin
                // A load is refused while the stored line still owes repeats.
                if (repeats_owed != 0) begin
                    push_error();
                    return;
                end
                line_pix[load_col] = item.pixel_in;
                written[load_col]  = 1'b1;
                // A column at or past the last one ends the line, which covers a width
                // that shrank while the line was half loaded.
                eol = (load_col + 1 >= wid);
                push_run(item.pixel_in, eol);
                if (eol) begin
                    load_col     = '0;
                    replay_col   = '0;
                    repeats_owed = 4'(eff_scale(sy_reg) - 1);
                end else begin
                    load_col = load_col + 1'b1;
                end
            end else begin
                if (repeats_owed == 0) begin
                    push_error();
                    return;
                end
                eol = (replay_col + 1 >= wid);
                push_run(line_pix[replay_col], eol);
                if (eol) begin
                    replay_col   = '0;
                    repeats_owed = repeats_owed - 1'b1;
                end else begin
                    replay_col = replay_col + 1'b1;
                end
            end
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 40) $display("mismatch at output word %0d: %s", words_checked, msg);
        endtask

        task check_output(t_out_word got);
            t_out_word want;
            words_checked++;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report_mismatch($sformatf("pixel_out %h, expected %h", got.pixel_out,
                                          want.pixel_out));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, expected %b", got.last_of_run,
                                          want.last_of_run));
            if (got.end_of_line !== want.end_of_line)
                report_mismatch($sformatf("end_of_line %b, expected %b", got.end_of_line,
                                          want.end_of_line));
            if (got.order_error !== want.order_error)
                report_mismatch($sformatf("order_error %b, expected %b", got.order_error,
                                          want.order_error));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    t_in_word                  in_word;
    logic                      out_ready;
    logic                      o_cfg_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    t_out_word                 o_out_word;

    upscale_scoreboard sb = new();

    // Idling controls: a calm side never idles; hold_left is a long hold-off of the
    // output side, counted down by the receiver itself.
    bit          in_calm;
    bit          out_calm;
    int unsigned out_stall;
    int unsigned hold_left;

    pixel_replication_upscaler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready changes on the falling edge only. After each accepted word it draws
    // a stall; a requested hold-off overrides everything while it lasts.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (o_out_valid && out_ready) begin
            sb.check_output(o_out_word);
            out_stall = out_calm ? 0 : $urandom_range(0, 9);
        end
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    // Offers one input word after a drawn gap and notes it once accepted. Valid stays high
    // after acceptance, so the caller's next action must be another send or a release.
    task automatic send_word(input t_in_word item);
        int unsigned gap;
        gap = in_calm ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= item;
        do @(posedge clk); while (!o_in_ready);
        sb.take_input(item);
    endtask

    task automatic send_load(input logic [PIX_WORD_BITS-1:0] pix);
        t_in_word item;
        item.opcode   = OP_LOAD;
        item.pixel_in = pix;
        send_word(item);
    endtask

    // The pixel field of a replay is unused; it carries noise.
    task automatic send_replay();
        t_in_word item;
        item.opcode   = OP_REPLAY;
        item.pixel_in = $urandom;
        send_word(item);
    endtask

    // Drops valid and waits until every predicted word has come out.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        do @(posedge clk); while (!o_cfg_ready);
        sb.write_reg(idx, CFG_DATA_BITS'(val));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_scale();
        int unsigned odd [4] = '{0, 16, 17, 31};
        if ($urandom_range(0, 9) == 0) return odd[$urandom_range(0, 3)];
        return $urandom_range(1, 4);
    endfunction

    // One random phase: set the registers while idle, then send words that mostly follow
    // the expected load and replay order, with some out-of-order words mixed in.
    task automatic run_phase(input int unsigned n_items, input int unsigned sx,
                             input int unsigned sy, input int unsigned w, input bit squeeze);
        int unsigned cap;
        t_in_word    item;
        wait_drain();
        // With repeats still owed, a wider line would replay columns never loaded, so the
        // width is held to the run of columns that have been written.
        if (sb.repeats_owed != 0) begin
            cap = 0;
            while (cap < LINE_DEPTH && sb.written[cap]) cap++;
            if (w > cap) w = cap;
        end
        write_cfg(CFG_SCALE_X, sx);
        write_cfg(CFG_SCALE_Y, sy);
        write_cfg(CFG_LINE_WIDTH, w);
        in_calm  = squeeze || ($urandom_range(0, 3) == 0);
        out_calm = !squeeze && ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < n_items; i++) begin
            item.opcode = (sb.repeats_owed != 0) ? OP_REPLAY : OP_LOAD;
            if ($urandom_range(0, 11) == 0) item.opcode = ~item.opcode;
            item.pixel_in = $urandom;
            send_word(item);
            // The sender keeps pushing while the receiver is held, so the block fills up.
            if (squeeze && i == 2) hold_left = 400;
            if (!squeeze && $urandom_range(0, 39) == 0) wait_drain();
        end
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned n;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        in_calm   = 1'b0;
        out_calm  = 1'b0;
        out_stall = 0;
        hold_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight after reset all registers hold one: a replay has nothing to repeat,
        // and loads of the extreme pixels each form a whole line.
        send_replay();
        send_load(32'h0000_0000);
        send_load(32'hFFFF_FFFF);
        send_replay();

        // A zero horizontal scale acts as one. The third load arrives while repeats are
        // owed and is refused; the vertical scale then changes with repeats still owed.
        wait_drain();
        write_cfg(CFG_SCALE_X, 0);
        write_cfg(CFG_SCALE_Y, 3);
        write_cfg(CFG_LINE_WIDTH, 2);
        send_load(32'hA5A5_A5A5);
        send_load(32'h5A5A_5A5A);
        send_load(32'hC3C3_C3C3);
        send_replay();
        wait_drain();
        write_cfg(CFG_SCALE_Y, 0);
        send_replay();
        send_replay();
        send_replay();
        send_replay();

        // The largest horizontal scale value, and a width that shrinks mid-line.
        wait_drain();
        write_cfg(CFG_SCALE_X, 31);
        write_cfg(CFG_LINE_WIDTH, 4);
        send_load($urandom);
        send_load($urandom);
        wait_drain();
        write_cfg(CFG_LINE_WIDTH, 1);
        send_load($urandom);

        // A scale just above the cap, and a width cut to zero while a repeat is half done.
        wait_drain();
        write_cfg(CFG_SCALE_X, 17);
        write_cfg(CFG_SCALE_Y, 2);
        write_cfg(CFG_LINE_WIDTH, 3);
        send_load($urandom);
        send_load($urandom);
        send_load($urandom);
        send_replay();
        wait_drain();
        write_cfg(CFG_LINE_WIDTH, 0);
        send_replay();

        // Random phases; the first two fix the largest scales and the input stall case.
        run_phase(30, 16, 31, 1, 1'b0);
        run_phase(60, 4, 2, 5, 1'b1);
        random_sent = 90;
        while (random_sent < 400) begin
            n = $urandom_range(15, 50);
            run_phase(n, pick_scale(), pick_scale(),
                      ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8), 1'b0);
            random_sent += n;
        end

        // The width register at its top value acts as the full line store, so a few
        // loads after the owed repeats are cleared all stay inside one line.
        while (sb.repeats_owed != 0) send_replay();
        wait_drain();
        write_cfg(CFG_SCALE_X, 1);
        write_cfg(CFG_SCALE_Y, 2);
        write_cfg(CFG_LINE_WIDTH, 8191);
        for (int unsigned i = 0; i < 8; i++) begin
            send_load($urandom);
        end

        wait_drain();
        repeat (16) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/pru_queue.sv
rtl/pru_front.sv
rtl/pru_back.sv
rtl/pixel_replication_upscaler.sv
tb/tb.sv
